>>> rtl/cpde_pkg.sv
// shared types, constants and helpers of the convex planes distance evaluator
`timescale 1ns / 1ps
package cpde_pkg;

  localparam int MaxPlanes = 8;
  localparam int IdxW      = (MaxPlanes > 1) ? $clog2(MaxPlanes) : 1;
  localparam int CntW      = $clog2(MaxPlanes + 1);
  localparam int CfgW      = 4;
  localparam int SlotW     = 3;
  localparam int CoordW    = 32;
  localparam int NormW     = 18;
  localparam int DiffW     = CoordW + 1;
  localparam int ProdW     = DiffW + NormW;
  localparam int SumW      = ProdW + 2;
  localparam int FracW     = 16;
  localparam int ShW       = SumW - FracW;

  localparam int InDataW   = 160;
  localparam int OutDataW  = 88;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdEval  = 1'b1
  } cmd_e;

  typedef enum logic {
    StatusOk    = 1'b0,
    StatusEmpty = 1'b1
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] ox;
    logic signed [CoordW-1:0] oy;
    logic signed [CoordW-1:0] oz;
    logic signed [NormW-1:0]  nx;
    logic signed [NormW-1:0]  ny;
    logic signed [NormW-1:0]  nz;
  } plane_t;

  // sequencer tags for one table read
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } issue_t;

  typedef struct packed {
    logic                   done;
    logic signed [SumW-1:0] best;
    logic signed [NormW-1:0] gx;
    logic signed [NormW-1:0] gy;
    logic signed [NormW-1:0] gz;
  } eval_res_t;

  // floor shift by the fraction width, then clamp to the signed 32-bit range
  function automatic logic [CoordW-1:0] sat_dist(input logic signed [SumW-1:0] s);
    logic signed [ShW-1:0] sh;
    logic [CoordW-1:0]     r;
    sh = s[SumW-1:FracW];
    if (sh[ShW-1:CoordW-1] == '0 || sh[ShW-1:CoordW-1] == '1) begin
      r = sh[CoordW-1:0];
    end else if (sh[ShW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/convex_planes_distance_eval.sv
// top level: stream ports, plane count register, read sequencer and result register
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: slot, origin/point, normal
//  m_axis   | out       | tuser: status; tdata: distance, gradient
//  cfg      | in        | plane count, 4 bits
//
//  a write beat stores a plane and gives no result.
//  an evaluate beat visits the active planes one table read per cycle and
//  shows its result once the datapath has taken the last plane (with no
//  planes, directly as the empty status).
//  one item is in work at a time; the next is taken once the result is in
//  the output register, which holds under m_axis_tready low.
//  reset clears control state and the plane count; the table stays unknown.
`timescale 1ns / 1ps
module convex_planes_distance_eval
  import cpde_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // slot, coord_x/y/z, normal_x/y/z
  input  logic                s_axis_tuser,  // command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // distance, grad_x, grad_y, grad_z
  output logic                m_axis_tuser   // status
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StIssue = 4'b0010,
    StDrain = 4'b0100,
    StHold  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0] count_cfg_q;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_in;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            empty_q, empty_d;

  logic signed [CoordW-1:0] px_q, py_q, pz_q;

  logic [SlotW-1:0] in_slot;
  plane_t           in_plane;
  logic             in_fire, out_free, load_out, last_issue;

  logic                    ram_we, ram_re;
  plane_t                  ram_rdata;
  issue_t                  issue;
  eval_res_t               res;

  logic                   out_valid_q;
  logic [CoordW-1:0]      dist_q;
  logic [NormW-1:0]       ogx_q, ogy_q, ogz_q;
  logic                   status_q;

  assign in_slot     = s_axis_tdata[SlotW-1:0];
  assign in_plane.ox = s_axis_tdata[34:3];
  assign in_plane.oy = s_axis_tdata[66:35];
  assign in_plane.oz = s_axis_tdata[98:67];
  assign in_plane.nx = s_axis_tdata[116:99];
  assign in_plane.ny = s_axis_tdata[134:117];
  assign in_plane.nz = s_axis_tdata[152:135];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // counts above the table depth use the whole table
  assign cnt_in = (count_cfg_q > CfgW'(MaxPlanes)) ? CntW'(MaxPlanes) : CntW'(count_cfg_q);

  assign ram_we = in_fire && (s_axis_tuser == CmdWrite) &&
                  ((SlotW + 8)'(in_slot) < (SlotW + 8)'(MaxPlanes));
  assign ram_re = (state_q == StIssue);

  assign last_issue = (CntW'(idx_q) == cnt_q - CntW'(1));

  always_comb begin
    issue.valid = (state_q == StIssue);
    issue.first = (idx_q == '0);
    issue.last  = last_issue;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    empty_d  = empty_q;
    load_out = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_fire && s_axis_tuser == CmdEval) begin
          cnt_d = cnt_in;
          idx_d = '0;
          if (cnt_in == '0) begin
            empty_d = 1'b1;
            state_d = StHold;
          end else begin
            empty_d = 1'b0;
            state_d = StIssue;
          end
        end
      end
      StIssue: begin
        if (last_issue) begin
          state_d = StDrain;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StDrain: begin
        if (res.done) begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_cfg_q <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      empty_q <= empty_d;
      if (cfg_valid_i) begin
        count_cfg_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser == CmdEval) begin
      px_q <= in_plane.ox;
      py_q <= in_plane.oy;
      pz_q <= in_plane.oz;
    end
    if (load_out) begin
      if (empty_q) begin
        dist_q   <= {1'b0, {(CoordW-1){1'b1}}};
        ogx_q    <= '0;
        ogy_q    <= '0;
        ogz_q    <= '0;
        status_q <= StatusEmpty;
      end else begin
        dist_q   <= sat_dist(res.best);
        ogx_q    <= res.gx;
        ogy_q    <= res.gy;
        ogz_q    <= res.gz;
        status_q <= StatusOk;
      end
    end
  end

  cpde_plane_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(in_slot)),
    .wdata_i (in_plane),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  cpde_plane_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .plane_i (ram_rdata),
    .px_i    (px_q),
    .py_i    (py_q),
    .pz_i    (pz_q),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, ogz_q, ogy_q, ogx_q, dist_q};
  assign m_axis_tuser  = status_q;

endmodule

>>> rtl/cpde_plane_ram.sv
// plane table memory, one write port and one registered read port
`timescale 1ns / 1ps
module cpde_plane_ram
  import cpde_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  plane_t          wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output plane_t          rdata_o
);

  plane_t mem [MaxPlanes];
  plane_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cpde_plane_eval.sv
// per-plane datapath: difference, products, sum and running maximum
`timescale 1ns / 1ps
module cpde_plane_eval
  import cpde_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  issue_t                   issue_i,
  input  plane_t                   plane_i,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  input  logic signed [CoordW-1:0] pz_i,
  output eval_res_t                res_o
);

  issue_t s0_q, s1_q, s2_q, s3_q;
  logic   done_q;

  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  logic signed [NormW-1:0] n1x_q, n1y_q, n1z_q;
  logic signed [ProdW-1:0] prx_q, pry_q, prz_q;
  logic signed [NormW-1:0] n2x_q, n2y_q, n2z_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [NormW-1:0] n3x_q, n3y_q, n3z_q;
  logic signed [SumW-1:0]  best_q, best_d;
  logic signed [NormW-1:0] gx_q, gy_q, gz_q, gx_d, gy_d, gz_d;

  // s0 lines up with the registered table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q   <= '0;
      s1_q   <= '0;
      s2_q   <= '0;
      s3_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s0_q   <= issue_i;
      s1_q   <= s0_q;
      s2_q   <= s1_q;
      s3_q   <= s2_q;
      done_q <= s3_q.valid && s3_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= DiffW'(px_i) - DiffW'(plane_i.ox);
    dy_q  <= DiffW'(py_i) - DiffW'(plane_i.oy);
    dz_q  <= DiffW'(pz_i) - DiffW'(plane_i.oz);
    n1x_q <= plane_i.nx;
    n1y_q <= plane_i.ny;
    n1z_q <= plane_i.nz;

    prx_q <= ProdW'(dx_q) * ProdW'(n1x_q);
    pry_q <= ProdW'(dy_q) * ProdW'(n1y_q);
    prz_q <= ProdW'(dz_q) * ProdW'(n1z_q);
    n2x_q <= n1x_q;
    n2y_q <= n1y_q;
    n2z_q <= n1z_q;

    sum_q <= SumW'(prx_q) + SumW'(pry_q) + SumW'(prz_q);
    n3x_q <= n2x_q;
    n3y_q <= n2y_q;
    n3z_q <= n2z_q;

    best_q <= best_d;
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    gz_q   <= gz_d;
  end

  // strict greater keeps the lowest slot on ties
  always_comb begin
    best_d = best_q;
    gx_d   = gx_q;
    gy_d   = gy_q;
    gz_d   = gz_q;
    if (s3_q.valid && (s3_q.first || sum_q > best_q)) begin
      best_d = sum_q;
      gx_d   = n3x_q;
      gy_d   = n3y_q;
      gz_d   = n3z_q;
    end
  end

  assign res_o.done = done_q;
  assign res_o.best = best_q;
  assign res_o.gx   = gx_q;
  assign res_o.gy   = gy_q;
  assign res_o.gz   = gz_q;

endmodule
